// ===== sv/tle_pkg.sv =====
// Package: character codes, item kinds and limits for the terminal line editor.
package tle_pkg;

  localparam int LINE_MAX_DEF = 256;
  localparam int CAP_W        = 9;
  localparam int POS_W        = 8;
  localparam int CHAR_W       = 8;
  localparam int OUT_DATA_W   = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 9'd128;
  localparam logic [CAP_W-1:0]  CAP_ABS   = 9'd256;

  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  typedef enum logic [2:0] {
    K_NONE,
    K_BS3,
    K_CRLF,
    K_LF,
    K_PRINT,
    K_BELL
  } kind_t;

endpackage

// ===== sv/terminal_line_editor.sv =====
// Top level: terminal line editor turning received characters into echo and store items.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | in_tdata: rx_char
//  out_    | master    | out_tvalid/tready  | out_tdata: echo and store fields, out_tlast: last
//  cfg_    | write     | cfg_wr_en          | cfg_wr_data: line_capacity
//
// An item passes an input buffer, is decoded into a plan register and then
// issues one result per cycle from that plan while out_ does not stall: 1 to 3 results,
// set by the item kind in the plan register. Ignored characters leave the buffer with no result.
// Reset clears the position, the capacity (to 128) and all valid flags; no clearing pass.
// A stall on out_ holds the plan; the input buffer takes one more item meanwhile.
module terminal_line_editor #(
  parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tle_pkg::CHAR_W-1:0]      in_tdata,     // [7:0] rx_char
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] echo_valid, [8:1] echo_char, [9] store_valid, [17:10] store_char,
  // [25:18] store_position, [26] line_done, [31:27] zero
  output logic [tle_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,    // last
  input  logic                            cfg_wr_en,
  input  logic [tle_pkg::CAP_W-1:0]       cfg_wr_data   // line_capacity
);

  localparam int CAP_LIM_I = (LINE_MAX > 256) ? 256 : LINE_MAX;
  localparam logic [tle_pkg::CAP_W-1:0] CAP_LIM = tle_pkg::CAP_W'(CAP_LIM_I);

  logic [tle_pkg::CAP_W-1:0]  cap_r;
  logic [tle_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       ibuf_v_r;
  logic [tle_pkg::CHAR_W-1:0] ibuf_r;
  logic                       plan_v_r;
  tle_pkg::kind_t             plan_kind_r, ld_kind;
  logic [tle_pkg::CHAR_W-1:0] plan_char_r, ld_char;
  logic [tle_pkg::POS_W-1:0]  plan_pos_r;
  logic [1:0]                 idx_r;

  logic [tle_pkg::CAP_W-1:0]  eff_cap;
  logic [tle_pkg::CHAR_W-1:0] c_in;
  logic                       room;
  logic                       plan_free, load_en, out_fire;

  logic                       o_store;
  logic [tle_pkg::CHAR_W-1:0] o_echo, o_schar;
  logic [tle_pkg::POS_W-1:0]  o_spos;
  logic                       o_done, o_last;

  assign eff_cap = (cap_r > CAP_LIM) ? CAP_LIM : cap_r;
  assign room    = ({1'b0, pos_r} + 9'd2) < eff_cap;

  assign out_fire  = out_tvalid && out_tready;
  assign plan_free = !plan_v_r || (out_fire && o_last);
  assign load_en   = ibuf_v_r && plan_free;
  assign in_tready = !ibuf_v_r || plan_free;

  always_comb begin
    c_in    = (ibuf_r == tle_pkg::CH_TAB) ? tle_pkg::CH_SPACE : ibuf_r;
    ld_char = c_in;
    pos_nxt = pos_r;
    priority if (c_in == tle_pkg::CH_BS || c_in == tle_pkg::CH_DEL) begin
      if (pos_r == '0) begin
        ld_kind = tle_pkg::K_NONE;
      end else begin
        ld_kind = tle_pkg::K_BS3;
        pos_nxt = pos_r - 8'd1;
      end
    end else if (c_in == tle_pkg::CH_CR) begin
      ld_kind = tle_pkg::K_CRLF;
      pos_nxt = '0;
    end else if (c_in == tle_pkg::CH_LF) begin
      ld_kind = tle_pkg::K_LF;
      pos_nxt = '0;
    end else if (c_in >= tle_pkg::CH_SPACE && c_in <= tle_pkg::CH_TILDE) begin
      if (room) begin
        ld_kind = tle_pkg::K_PRINT;
        pos_nxt = pos_r + 8'd1;
      end else begin
        ld_kind = tle_pkg::K_BELL;
      end
    end else begin
      ld_kind = tle_pkg::K_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= tle_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ibuf_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      ibuf_v_r <= 1'b1;
      ibuf_r   <= in_tdata;
    end else if (load_en) begin
      ibuf_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_v_r <= 1'b0;
      pos_r    <= '0;
      idx_r    <= '0;
    end else if (load_en) begin
      plan_v_r    <= (ld_kind != tle_pkg::K_NONE);
      plan_kind_r <= ld_kind;
      plan_char_r <= ld_char;
      plan_pos_r  <= pos_r;
      pos_r       <= pos_nxt;
      idx_r       <= '0;
    end else if (out_fire) begin
      if (o_last) begin
        plan_v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_comb begin
    o_echo  = tle_pkg::CH_BELL;
    o_store = 1'b0;
    o_schar = '0;
    o_spos  = '0;
    o_done  = 1'b0;
    o_last  = 1'b1;
    unique case (plan_kind_r)
      tle_pkg::K_BS3: begin
        o_echo = (idx_r == 2'd1) ? tle_pkg::CH_SPACE : tle_pkg::CH_BS;
        o_last = (idx_r == 2'd2);
      end
      tle_pkg::K_CRLF: begin
        o_store = 1'b1;
        if (idx_r == 2'd0) begin
          o_echo  = tle_pkg::CH_CR;
          o_schar = tle_pkg::CH_CR;
          o_spos  = plan_pos_r;
          o_last  = 1'b0;
        end else begin
          o_echo  = tle_pkg::CH_LF;
          o_schar = tle_pkg::CH_LF;
          o_spos  = plan_pos_r + 8'd1;
          o_done  = 1'b1;
        end
      end
      tle_pkg::K_LF: begin
        o_echo  = tle_pkg::CH_LF;
        o_store = 1'b1;
        o_schar = tle_pkg::CH_LF;
        o_spos  = plan_pos_r;
        o_done  = 1'b1;
      end
      tle_pkg::K_PRINT: begin
        o_echo  = plan_char_r;
        o_store = 1'b1;
        o_schar = plan_char_r;
        o_spos  = plan_pos_r;
      end
      default: begin
        o_echo = tle_pkg::CH_BELL;
      end
    endcase
  end

  assign out_tvalid = plan_v_r;
  assign out_tlast  = o_last;
  assign out_tdata  = {5'd0, o_done, o_spos, o_schar, o_store, o_echo, 1'b1};

  a_store_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[17:10] == out_tdata[8:1])
    else $error("store char differs from echo char");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tlast && out_tdata[17:10] == tle_pkg::CH_LF)
    else $error("line done without final LF item");

  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_en && (ld_kind == tle_pkg::K_LF || ld_kind == tle_pkg::K_CRLF) |=> pos_r == '0)
    else $error("position not cleared at end of line");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ibuf_v_r && plan_v_r)
    else $error("input stalled with free buffer");

endmodule

// ===== tb/terminal_line_editor_tb.sv =====
// Testbench for terminal_line_editor: directed and random character streams, checked item by item.
`timescale 1ns / 100ps

module terminal_line_editor_tb;

  localparam int TB_LINE_MAX = tle_pkg::LINE_MAX_DEF;

  typedef struct packed {
    logic [4:0]                 pad;
    logic                       line_done;
    logic [tle_pkg::POS_W-1:0]  store_pos;
    logic [tle_pkg::CHAR_W-1:0] store_char;
    logic                       store_valid;
    logic [tle_pkg::CHAR_W-1:0] echo_char;
    logic                       echo_valid;
    logic                       last;
  } echo_item_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [tle_pkg::CHAR_W-1:0]     in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b1;
  logic [tle_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           cfg_wr_en = 1'b0;
  logic [tle_pkg::CAP_W-1:0]      cfg_wr_data = '0;

  echo_item_t                pending_echo[$];
  logic [tle_pkg::POS_W-1:0] line_pos;
  logic [tle_pkg::CAP_W-1:0] line_cap;
  bit                        idle_en = 1'b1;
  int                        stall_left = 0;
  int                        mismatches = 0;
  int                        items_sent = 0;
  int                        results_seen = 0;
  int                        bells = 0;
  int                        lines_ended = 0;
  int                        caps_used = 0;

  terminal_line_editor #(.LINE_MAX(TB_LINE_MAX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string fmt_item(echo_item_t it);
    return $sformatf("echo=%0b/%h store=%0b/%h@%0d done=%0b last=%0b pad=%h",
                     it.echo_valid, it.echo_char, it.store_valid, it.store_char,
                     it.store_pos, it.line_done, it.last, it.pad);
  endfunction

  function automatic void report_mismatch(string what, echo_item_t want, echo_item_t got);
    if (mismatches < 10)
      $display("[%0t] %s\n  exp %s\n  got %s", $time, what, fmt_item(want), fmt_item(got));
    mismatches++;
  endfunction

  function automatic void push_echo(logic [tle_pkg::CHAR_W-1:0] echo, logic st,
                                    logic [tle_pkg::CHAR_W-1:0] sch,
                                    logic [tle_pkg::POS_W-1:0] spos, logic done, logic lst);
    echo_item_t it;
    it.pad         = '0;
    it.echo_valid  = 1'b1;
    it.echo_char   = echo;
    it.store_valid = st;
    it.store_char  = st ? sch : '0;
    it.store_pos   = st ? spos : '0;
    it.line_done   = done;
    it.last        = lst;
    pending_echo.push_back(it);
  endfunction

  function automatic void predict_edit(logic [tle_pkg::CHAR_W-1:0] rx);
    logic [tle_pkg::CHAR_W-1:0] c;
    int                         room;
    c    = (rx == tle_pkg::CH_TAB) ? tle_pkg::CH_SPACE : rx;
    room = int'(line_cap);
    if (room > TB_LINE_MAX) room = TB_LINE_MAX;
    if (room > int'(tle_pkg::CAP_ABS)) room = int'(tle_pkg::CAP_ABS);
    if (c == tle_pkg::CH_BS || c == tle_pkg::CH_DEL) begin
      if (line_pos != 0) begin
        push_echo(tle_pkg::CH_BS, 1'b0, '0, '0, 1'b0, 1'b0);
        push_echo(tle_pkg::CH_SPACE, 1'b0, '0, '0, 1'b0, 1'b0);
        push_echo(tle_pkg::CH_BS, 1'b0, '0, '0, 1'b0, 1'b1);
        line_pos = line_pos - 8'd1;
      end
    end else if (c == tle_pkg::CH_CR) begin
      push_echo(tle_pkg::CH_CR, 1'b1, tle_pkg::CH_CR, line_pos, 1'b0, 1'b0);
      push_echo(tle_pkg::CH_LF, 1'b1, tle_pkg::CH_LF, line_pos + 8'd1, 1'b1, 1'b1);
      line_pos = '0;
      lines_ended++;
    end else if (c == tle_pkg::CH_LF) begin
      push_echo(tle_pkg::CH_LF, 1'b1, tle_pkg::CH_LF, line_pos, 1'b1, 1'b1);
      line_pos = '0;
      lines_ended++;
    end else if (c >= tle_pkg::CH_SPACE && c <= tle_pkg::CH_TILDE) begin
      if (int'(line_pos) + 2 < room) begin
        push_echo(c, 1'b1, c, line_pos, 1'b0, 1'b1);
        line_pos = line_pos + 8'd1;
      end else begin
        push_echo(tle_pkg::CH_BELL, 1'b0, '0, '0, 1'b0, 1'b1);
        bells++;
      end
    end
  endfunction

  always @(posedge clk) begin : check_results
    echo_item_t got;
    echo_item_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:27], out_tdata[26], out_tdata[25:18], out_tdata[17:10],
               out_tdata[9], out_tdata[8:1], out_tdata[0], out_tlast};
        results_seen++;
        if (pending_echo.size() == 0) begin
          report_mismatch("unexpected item", '0, got);
        end else begin
          want = pending_echo.pop_front();
          if (got !== want) report_mismatch("item mismatch", want, got);
        end
      end
      if (idle_en && stall_left == 0 && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 3);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [tle_pkg::CHAR_W-1:0] ch);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_edit(ch);
    items_sent++;
  endtask

  // hold the input until every expected item is back, then let ignored ones flush
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_echo.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [tle_pkg::CAP_W-1:0] cap);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    line_cap = cap;
    caps_used++;
  endtask

  function automatic logic [tle_pkg::CHAR_W-1:0] rand_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 66)
      return tle_pkg::CHAR_W'($urandom_range(tle_pkg::CH_SPACE, tle_pkg::CH_TILDE));
    if (pick < 74) return $urandom_range(0, 1) ? tle_pkg::CH_BS : tle_pkg::CH_DEL;
    if (pick < 79) return tle_pkg::CH_TAB;
    if (pick < 85) return tle_pkg::CH_CR;
    if (pick < 89) return tle_pkg::CH_LF;
    if ($urandom_range(0, 1)) return tle_pkg::CHAR_W'($urandom_range(0, 31));
    return tle_pkg::CHAR_W'($urandom_range(128, 255));
  endfunction

  function automatic logic [tle_pkg::CHAR_W-1:0] rand_print();
    return tle_pkg::CHAR_W'($urandom_range(tle_pkg::CH_SPACE, tle_pkg::CH_TILDE));
  endfunction

  task automatic test_directed();
    logic [tle_pkg::CHAR_W-1:0] seq[$];
    seq = '{tle_pkg::CH_BS, tle_pkg::CH_DEL, tle_pkg::CH_SPACE, tle_pkg::CH_TILDE,
            tle_pkg::CH_TAB, "A", tle_pkg::CH_BS, "B", tle_pkg::CH_DEL,
            8'h00, 8'h1F, 8'h80, 8'hFF, 8'h0B, tle_pkg::CH_BELL, "h", "i", tle_pkg::CH_CR,
            "x", tle_pkg::CH_LF, tle_pkg::CH_LF, tle_pkg::CH_CR, 8'h55, 8'hAA};
    foreach (seq[i]) send_char(seq[i]);
  endtask

  task automatic test_small_capacity();
    logic [tle_pkg::CHAR_W-1:0] seq[$];
    set_capacity(9'd3);
    seq = '{"a", "b", tle_pkg::CH_TAB, tle_pkg::CH_BS, "c", "d", tle_pkg::CH_CR};
    foreach (seq[i]) send_char(seq[i]);
    set_capacity(9'd0);
    send_char("z");
    send_char(tle_pkg::CH_TAB);
    send_char(tle_pkg::CH_LF);
    set_capacity(9'd4);
    seq = '{"1", "2", "3", tle_pkg::CH_DEL, "4", tle_pkg::CH_LF};
    foreach (seq[i]) send_char(seq[i]);
  endtask

  task automatic test_lowered_capacity();
    set_capacity(tle_pkg::CAP_RESET);
    repeat (20) send_char(rand_print());
    set_capacity(9'd5);
    send_char("q");
    send_char(tle_pkg::CH_BS);
    send_char(tle_pkg::CH_TAB);
    send_char(tle_pkg::CH_CR);
  endtask

  task automatic test_full_line();
    set_capacity(9'd511);
    repeat (256) send_char(rand_print());
    send_char(tle_pkg::CH_BS);
    send_char("Z");
    send_char(tle_pkg::CH_CR);
    set_capacity(tle_pkg::CAP_ABS);
    send_char("e");
    send_char(tle_pkg::CH_LF);
  endtask

  task automatic test_random_lines();
    set_capacity(tle_pkg::CAP_ABS);
    repeat (20) send_char(rand_char());
    set_capacity(9'd3);
    repeat (15) send_char(rand_char());
    set_capacity(tle_pkg::CAP_W'($urandom_range(3, 256)));
    repeat (20) send_char(rand_char());
    set_capacity(9'd12);
    repeat (20) send_char(rand_char());
    set_capacity(tle_pkg::CAP_RESET);
    idle_en = 1'b0;
    repeat (20) send_char(rand_char());
  endtask

  initial begin
    #2_000_000;
    $display("terminal_line_editor_tb: FAIL");
    $finish;
  end

  initial begin
    line_pos = '0;
    line_cap = tle_pkg::CAP_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_capacity();
    test_lowered_capacity();
    test_full_line();
    test_random_lines();
    wait_drain();
    if (pending_echo.size() != 0) mismatches += pending_echo.size();
    $display("Sent %0d characters under %0d capacity settings; checked %0d echo items.",
             items_sent, caps_used, results_seen);
    $display("Lines ended: %0d, bells rung: %0d, mismatches: %0d.",
             lines_ended, bells, mismatches);
    if (mismatches == 0) begin
      $display("terminal_line_editor_tb: PASS");
    end else begin
      $display("terminal_line_editor_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tle_pkg.sv
sv/terminal_line_editor.sv
tb/terminal_line_editor_tb.sv
